>>> rtl/sca_pkg.sv
// Shared types, constants and the size-class curve for the size-class slot allocator.
// No dependencies; every other file but sca_ram refers to this package by scoped names.
`default_nettype none
package sca_pkg;
	localparam int NUM_CLASSES_DEF = 16;
	localparam int MAX_SLOTS_DEF   = 4096;
	localparam int ADDR_W          = 32;
	localparam int POOL_W          = 28;
	localparam int CNT_W           = 13;
	localparam int CURVE_W         = 11;
	localparam int PROD_W          = CURVE_W + POOL_W;
	localparam int REM_W           = 27;
	localparam int DIV_K           = 10000;
	localparam int CIDX_W          = 2;
	localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
	localparam logic [POOL_W-1:0] POOL_RESET = 28'd16777216;
	localparam logic [ADDR_W-1:0] BASE_RESET = 32'd0;
	// dividends at or above this value clamp the quotient to COUNT_MAX
	localparam logic [PROD_W-1:0] CLAMP_LIM = PROD_W'((COUNT_MAX + 1) * DIV_K);
	// divide by DIV_K as a multiply by ceil(2^RECIP_SH / DIV_K), exact below 2^REM_W
	localparam int RECIP_W  = 28;
	localparam int RECIP_SH = 41;
	localparam logic [RECIP_W-1:0] RECIP_M = 28'd219902326;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	localparam logic [CIDX_W-1:0] REG_POOL_SIZE = 2'd0;
	localparam logic [CIDX_W-1:0] REG_DATA_BASE = 2'd1;

	// slot share per class in ten-thousandths
	function automatic logic [CURVE_W-1:0] curve_e4(input logic [3:0] c);
		logic [CURVE_W-1:0] v;
		case (c)
			4'd0, 4'd15: v = 11'd19;
			4'd1, 4'd14: v = 11'd56;
			4'd2, 4'd13: v = 11'd146;
			4'd3, 4'd12: v = 11'd320;
			4'd4, 4'd11: v = 11'd603;
			4'd5, 4'd10: v = 11'd968;
			4'd6, 4'd9:  v = 11'd1327;
			4'd7, 4'd8:  v = 11'd1554;
			default:     v = 11'd0;
		endcase
		return v;
	endfunction

	// controller to datapath commands
	typedef struct packed {
		logic lay_start;
		logic mul;
		logic div_init;
		logic div_step;
		logic lay_write;
		logic clr_start;
		logic clr_step;
		logic op_load;
		logic afind;
		logic j_inc;
		logic alloc_hit;
		logic free_hit;
		logic cls_inc;
		logic set_toolarge;
		logic set_full;
		logic set_notfound;
		logic out_load;
	} sca_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic too_large;
		logic cnt_zero;
		logic used_bit;
		logic scan_last;
		logic fmatch;
		logic fcls_last;
		logic lay_last;
		logic clr_last;
	} sca_stat_t;
endpackage
`default_nettype wire

>>> rtl/sca_if.sv
// Valid/ready channel interfaces: request, result and configuration write.
// Depends on sca_pkg for field widths.
`default_nettype none
interface sca_req_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [sca_pkg::ADDR_W-1:0] request_bytes;
	logic [sca_pkg::ADDR_W-1:0] free_addr;
	modport source (output valid, func, request_bytes, free_addr, input ready);
	modport sink   (input valid, func, request_bytes, free_addr, output ready);
endinterface

interface sca_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [sca_pkg::ADDR_W-1:0] slot_addr;
	logic [1:0]                 status;
	modport source (output valid, slot_addr, status, input ready);
	modport sink   (input valid, slot_addr, status, output ready);
endinterface

interface sca_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sca_pkg::CIDX_W-1:0] idx;
	logic [sca_pkg::ADDR_W-1:0] wdata;
	modport source (output valid, idx, wdata, input ready);
	modport sink   (input valid, idx, wdata, output ready);
endinterface
`default_nettype wire

>>> rtl/sca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sca_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/sca_datapath.sv
// Datapath: configuration registers, layout builder (multiplier, reciprocal divider),
// class tables, used-flag RAM, request registers and result register. Uses sca_pkg, sca_ram.
`default_nettype none
module sca_datapath #(
	parameter int NUM_CLASSES = sca_pkg::NUM_CLASSES_DEF,
	parameter int MAX_SLOTS   = sca_pkg::MAX_SLOTS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  sca_pkg::sca_cmd_t            cmd,
	output sca_pkg::sca_stat_t           stat,
	input  wire                          cfg_wr,
	input  wire [sca_pkg::CIDX_W-1:0]    cfg_idx,
	input  wire [sca_pkg::ADDR_W-1:0]    cfg_wdata,
	input  wire [sca_pkg::ADDR_W-1:0]    in_request_bytes,
	input  wire [sca_pkg::ADDR_W-1:0]    in_free_addr,
	output logic [sca_pkg::ADDR_W-1:0]   out_slot_addr_q,
	output logic [1:0]                   out_status_q
);
	localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int CC_W   = CLS_W + 1;
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int NS_W   = SLOT_W + 1;
	localparam int AW     = sca_pkg::ADDR_W;
	localparam int CW     = sca_pkg::CNT_W;
	localparam int RP_W   = sca_pkg::REM_W + sca_pkg::RECIP_W;

	logic [sca_pkg::POOL_W-1:0] pool_q;
	logic [AW-1:0]              base_q;
	logic [sca_pkg::PROD_W-1:0] prod_q;
	logic [sca_pkg::REM_W-1:0]  rem_q;
	logic [CW-1:0]              quo_q;
	logic                       clamp_q;
	logic [CC_W-1:0]            cls_q;
	logic [NS_W-1:0]            next_slot_q;
	logic [AW-1:0]              addr_acc_q;
	logic [NS_W-1:0]            clr_q;
	logic [CW-1:0]              cnt_q        [NUM_CLASSES];
	logic [NS_W-1:0]            first_slot_q [NUM_CLASSES];
	logic [AW-1:0]              first_addr_q [NUM_CLASSES];
	logic [AW-1:0]              req_q;
	logic [AW-1:0]              faddr_q;
	logic [CLS_W-1:0]           acls_q;
	logic [CW-1:0]              j_q;

	logic [CLS_W-1:0]           cls_idx;
	logic [sca_pkg::PROD_W-1:0] quot_sh;
	logic [RP_W-1:0]            recip_p;
	logic [CW-1:0]              n_cl;
	logic [NS_W-1:0]            room;
	logic [CW-1:0]              cnt_new;
	logic [CLS_W-1:0]           acls_c;
	logic                       found_c;
	logic [AW-1:0]              fd;
	logic [AW-1:0]              fj_wide;
	logic [AW-1:0]              rd_slot;
	logic [AW-1:0]              fr_slot;
	logic [AW-1:0]              alloc_addr;
	logic                       ram_we;
	logic [SLOT_W-1:0]          ram_waddr;
	logic                       ram_wdata;
	logic                       used_rd;

	assign cls_idx = cls_q[CLS_W-1:0];

	// layout arithmetic for the current class
	always_comb begin
		quot_sh = prod_q >> (6'd10 + 6'(cls_idx));
		recip_p = RP_W'(rem_q) * RP_W'(sca_pkg::RECIP_M);
		n_cl    = clamp_q ? sca_pkg::COUNT_MAX : quo_q;
		room    = NS_W'(MAX_SLOTS) - next_slot_q;
		cnt_new = (32'(n_cl) > 32'(room)) ? CW'(room) : n_cl;
	end

	// class selection for an allocate: first class whose slot size exceeds the request
	always_comb begin
		acls_c  = '0;
		found_c = 1'b0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (!found_c && ({1'b0, req_q} < (33'd1 << (c + 5)))) begin
				acls_c  = CLS_W'(c);
				found_c = 1'b1;
			end
		end
	end

	// free address match against the current class, and the allocate slot index and address
	always_comb begin
		fd      = faddr_q - first_addr_q[cls_idx];
		fj_wide = fd >> (6'd5 + 6'(cls_idx));
		fr_slot = 32'(first_slot_q[cls_idx]) + fj_wide;
		rd_slot = 32'(first_slot_q[acls_q]) + 32'(j_q);
		alloc_addr = first_addr_q[acls_q] + AW'({19'd0, j_q} << (6'd5 + 6'(acls_q)));
	end

	always_comb begin
		stat.too_large = !found_c;
		stat.cnt_zero  = (cnt_q[acls_c] == '0);
		stat.used_bit  = used_rd;
		stat.scan_last = (j_q == cnt_q[acls_q] - CW'(1));
		stat.fmatch    = ((fd & ~(32'hFFFF_FFFF << (6'd5 + 6'(cls_idx)))) == '0)
			&& (fj_wide < 32'(cnt_q[cls_idx]));
		stat.fcls_last = (cls_q == CC_W'(NUM_CLASSES - 1));
		stat.lay_last  = (cls_q == CC_W'(NUM_CLASSES - 1));
		stat.clr_last  = (clr_q == NS_W'(MAX_SLOTS - 1));
	end

	// used-flag RAM write select: clear pass, allocate, free
	always_comb begin
		ram_we    = cmd.clr_step | cmd.alloc_hit | cmd.free_hit;
		ram_waddr = clr_q[SLOT_W-1:0];
		ram_wdata = 1'b0;
		if (cmd.alloc_hit) begin
			ram_waddr = rd_slot[SLOT_W-1:0];
			ram_wdata = 1'b1;
		end else if (cmd.free_hit) begin
			ram_waddr = fr_slot[SLOT_W-1:0];
		end
	end

	sca_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_used (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr   (rd_slot[SLOT_W-1:0]),
		.rdata_q (used_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= sca_pkg::POOL_RESET;
			base_q <= sca_pkg::BASE_RESET;
		end else if (cfg_wr) begin
			if (cfg_idx == sca_pkg::REG_POOL_SIZE) begin
				pool_q <= cfg_wdata[sca_pkg::POOL_W-1:0];
			end else if (cfg_idx == sca_pkg::REG_DATA_BASE) begin
				base_q <= cfg_wdata;
			end
		end
	end

	// sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q       <= '0;
			next_slot_q <= '0;
			clr_q       <= '0;
			j_q         <= '0;
			acls_q      <= '0;
		end else begin
			if (cmd.lay_start || cmd.op_load) begin
				cls_q <= '0;
			end else if (cmd.lay_write || cmd.cls_inc) begin
				cls_q <= cls_q + CC_W'(1);
			end
			if (cmd.lay_start) begin
				next_slot_q <= '0;
			end else if (cmd.lay_write) begin
				next_slot_q <= next_slot_q + NS_W'(cnt_new);
			end
			if (cmd.clr_start) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + NS_W'(1);
			end
			if (cmd.afind) begin
				j_q    <= '0;
				acls_q <= acls_c;
			end else if (cmd.j_inc) begin
				j_q <= j_q + CW'(1);
			end
		end
	end

	// layout payload: product, divide, class tables and request
	always_ff @(posedge clk) begin
		if (cmd.lay_start) begin
			addr_acc_q <= base_q;
		end
		if (cmd.mul) begin
			prod_q <= sca_pkg::PROD_W'(sca_pkg::curve_e4(4'(cls_idx))) * sca_pkg::PROD_W'(pool_q);
		end
		if (cmd.div_init) begin
			clamp_q <= (quot_sh >= sca_pkg::CLAMP_LIM);
			rem_q   <= quot_sh[sca_pkg::REM_W-1:0];
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			quo_q <= recip_p[sca_pkg::RECIP_SH +: CW];
		end
		if (cmd.lay_write) begin
			cnt_q[cls_idx]        <= cnt_new;
			first_slot_q[cls_idx] <= next_slot_q;
			first_addr_q[cls_idx] <= addr_acc_q;
			addr_acc_q <= addr_acc_q + AW'({20'd0, cnt_new} << (6'd5 + 6'(cls_idx)));
		end
		if (cmd.op_load) begin
			req_q   <= in_request_bytes;
			faddr_q <= in_free_addr;
		end
	end

	// result and output registers
	logic [AW-1:0] res_addr_q;
	logic [1:0]    res_st_q;
	always_ff @(posedge clk) begin
		if (cmd.alloc_hit) begin
			res_addr_q <= alloc_addr;
			res_st_q   <= sca_pkg::ST_OK;
		end else if (cmd.free_hit) begin
			res_addr_q <= '0;
			res_st_q   <= sca_pkg::ST_OK;
		end else if (cmd.set_toolarge) begin
			res_addr_q <= '0;
			res_st_q   <= sca_pkg::ST_TOO_LARGE;
		end else if (cmd.set_full) begin
			res_addr_q <= '0;
			res_st_q   <= sca_pkg::ST_FULL;
		end else if (cmd.set_notfound) begin
			res_addr_q <= '0;
			res_st_q   <= sca_pkg::ST_NOT_FOUND;
		end
		if (cmd.out_load) begin
			out_slot_addr_q <= res_addr_q;
			out_status_q    <= res_st_q;
		end
	end
endmodule
`default_nettype wire

>>> rtl/sca_ctrl.sv
// Controller state machine: layout build, clear pass, allocate scan, free search
// and the result handshake. Uses sca_pkg command and status types.
`default_nettype none
module sca_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr,
	input  wire                 in_valid,
	input  wire                 in_func,
	output logic                in_ready,
	output logic                out_valid_q,
	input  wire                 out_ready,
	output sca_pkg::sca_cmd_t   cmd,
	input  sca_pkg::sca_stat_t  stat
);
	typedef enum logic [11:0] {
		S_LSTART = 12'b0000_0000_0001,
		S_LMUL   = 12'b0000_0000_0010,
		S_LDIVI  = 12'b0000_0000_0100,
		S_LDIV   = 12'b0000_0000_1000,
		S_LWR    = 12'b0000_0001_0000,
		S_CLR    = 12'b0000_0010_0000,
		S_IDLE   = 12'b0000_0100_0000,
		S_AFIND  = 12'b0000_1000_0000,
		S_ARD    = 12'b0001_0000_0000,
		S_ACHK   = 12'b0010_0000_0000,
		S_FCHK   = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	// a register write in the same cycle takes precedence over a request
	assign in_ready = (state_q == S_IDLE) && !cfg_wr;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LSTART: begin
				cmd.lay_start = 1'b1;
				state_d = S_LMUL;
			end
			S_LMUL: begin
				cmd.mul = 1'b1;
				state_d = S_LDIVI;
			end
			S_LDIVI: begin
				cmd.div_init = 1'b1;
				state_d = S_LDIV;
			end
			S_LDIV: begin
				cmd.div_step = 1'b1;
				state_d = S_LWR;
			end
			S_LWR: begin
				cmd.lay_write = 1'b1;
				if (stat.lay_last) begin
					cmd.clr_start = 1'b1;
					state_d = S_CLR;
				end else begin
					state_d = S_LMUL;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && !cfg_wr) begin
					cmd.op_load = 1'b1;
					state_d = (in_func == sca_pkg::FUNC_FREE) ? S_FCHK : S_AFIND;
				end
			end
			S_AFIND: begin
				if (stat.too_large) begin
					cmd.set_toolarge = 1'b1;
					state_d = S_DONE;
				end else if (stat.cnt_zero) begin
					cmd.set_full = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.afind = 1'b1;
					state_d = S_ARD;
				end
			end
			S_ARD: begin
				state_d = S_ACHK;
			end
			S_ACHK: begin
				if (!stat.used_bit) begin
					cmd.alloc_hit = 1'b1;
					state_d = S_DONE;
				end else if (stat.scan_last) begin
					cmd.set_full = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.j_inc = 1'b1;
					state_d = S_ARD;
				end
			end
			S_FCHK: begin
				if (stat.fmatch) begin
					cmd.free_hit = 1'b1;
					state_d = S_DONE;
				end else if (stat.fcls_last) begin
					cmd.set_notfound = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.cls_inc = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_LSTART;
			end
		endcase
		// a register write rebuilds the layout
		if (cfg_wr) begin
			state_d = S_LSTART;
		end
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LSTART;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/size_class_slot_allocator.sv
// Top level of the size-class slot allocator: controller plus datapath.
// Uses sca_pkg, sca_if interfaces, sca_ctrl and sca_datapath.
//
//  channel  | dir | payload                           | transfer when
//  req_ch   | in  | func, request_bytes, free_addr    | valid & ready
//  rsp_ch   | out | slot_addr, status                 | valid & ready
//  cfg_ch   | in  | idx, wdata (pool_size, data_base) | valid & ready (ready always high)
//
// Allocate: pick the class, then read and check the used flag of each slot in turn (lowest
// free slot first), then load the result register; a too-large request or empty class skips
// the scan. Free: search the classes in turn, up to NUM_CLASSES, then load the result register.
// After reset and after every register write the layout is rebuilt class by class (product,
// shift and clamp, reciprocal divide, table write), followed by a clear pass over all
// MAX_SLOTS entries of the used-flag RAM; no request is taken meanwhile. A request may be
// taken while the previous result still waits in the output register; a stalled result
// then holds the next one, and the request port, until the output register frees.
`default_nettype none
module size_class_slot_allocator #(
	parameter int NUM_CLASSES = sca_pkg::NUM_CLASSES_DEF,
	parameter int MAX_SLOTS   = sca_pkg::MAX_SLOTS_DEF
) (
	input  wire       clk,
	input  wire       arst_n,
	sca_req_if.sink   req_ch,
	sca_rsp_if.source rsp_ch,
	sca_cfg_if.sink   cfg_ch
);
	sca_pkg::sca_cmd_t  cmd;
	sca_pkg::sca_stat_t stat;
	logic               cfg_wr;

	// take register writes at any time; unknown indexes are dropped
	assign cfg_ch.ready = 1'b1;
	assign cfg_wr = cfg_ch.valid
		&& ((cfg_ch.idx == sca_pkg::REG_POOL_SIZE) || (cfg_ch.idx == sca_pkg::REG_DATA_BASE));

	sca_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.in_valid    (req_ch.valid),
		.in_func     (req_ch.func),
		.in_ready    (req_ch.ready),
		.out_valid_q (rsp_ch.valid),
		.out_ready   (rsp_ch.ready),
		.cmd         (cmd),
		.stat        (stat)
	);

	sca_datapath #(.NUM_CLASSES(NUM_CLASSES), .MAX_SLOTS(MAX_SLOTS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_wr           (cfg_wr),
		.cfg_idx          (cfg_ch.idx),
		.cfg_wdata        (cfg_ch.wdata),
		.in_request_bytes (req_ch.request_bytes),
		.in_free_addr     (req_ch.free_addr),
		.out_slot_addr_q  (rsp_ch.slot_addr),
		.out_status_q     (rsp_ch.status)
	);
endmodule
`default_nettype wire

>>> rtl/sca_checker.sv
// Port-level checker for the size-class slot allocator, attached by bind.
// Uses sca_pkg status codes.
`default_nettype none
module sca_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_valid,
	input wire                         in_ready,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire [sca_pkg::ADDR_W-1:0]   slot_addr,
	input wire [1:0]                   status,
	input wire                         cfg_valid,
	input wire [sca_pkg::CIDX_W-1:0]   cfg_idx
);
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_addr) && $stable(status))
		else $error("result changed while stalled");

	// failures carry a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != sca_pkg::ST_OK) |-> slot_addr == '0)
		else $error("failure result with nonzero address");

	// one request at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a register write starts a rebuild
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && ((cfg_idx == sca_pkg::REG_POOL_SIZE) || (cfg_idx == sca_pkg::REG_DATA_BASE))
		|=> !in_ready)
		else $error("request port open during layout rebuild");
endmodule

bind size_class_slot_allocator sca_checker u_sca_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req_ch.valid),
	.in_ready  (req_ch.ready),
	.out_valid (rsp_ch.valid),
	.out_ready (rsp_ch.ready),
	.slot_addr (rsp_ch.slot_addr),
	.status    (rsp_ch.status),
	.cfg_valid (cfg_ch.valid),
	.cfg_idx   (cfg_ch.idx)
);
`default_nettype wire
